// ===== rtl/mbfp_pkg.sv =====
`default_nettype none
package mbfp_pkg;

  // Frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_LEVELS = 10;

  // Field widths
  localparam int DIM_W   = 11;  // image dimension, 1..1024
  localparam int CNT_W   = 10;  // column / row counter within a level
  localparam int CRD_W   = 9;   // emitted coordinate
  localparam int LVL_W   = 4;   // emitted mip level
  localparam int CH_W    = 8;   // one colour channel
  localparam int PIX_W   = 3 * CH_W;
  localparam int PSUM_W  = CH_W + 1;      // horizontal pair sum per channel
  localparam int SUM_W   = 3 * PSUM_W;    // line store entry
  localparam int IN_W    = 24;            // input tdata
  localparam int OUT_W   = 48;            // result tdata
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } cfg_reg_t;

  // Clamp a programmed dimension into 1..hi
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mbfp_ram.sv =====
`default_nettype none
module mbfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mipmap_box_filter_pyramid_core.sv =====
// Channel  | dir | beat contents
// s_*      | in  | tdata: red, green, blue (8 bits each, red lowest)
// m_*      | out | tdata: level, column, row, red, green, blue; tlast: last of run
// cfg_*    | in  | cfg_index 0 width, 1 height, 11-bit cfg_data
//
// One mip level is stepped per cycle while no result waits stalled: a pixel steps
// each level that finishes a result, then the next one, which only advances, unless
// the deepest level finished. The next pixel is taken in the final step, so pixels that
// finish nothing go back to back. Each level has its own registered-read line store.
// rst is synchronous; it clears counters, held pixels and the handshakes.
// A waiting result with m_tready low freezes the level step; s_tready is low
// while further levels of a cascade remain.
`default_nettype none
module mipmap_box_filter_pyramid_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [mbfp_pkg::IN_W-1:0]       s_tdata,   // red, green, blue
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [mbfp_pkg::OUT_W-1:0]      m_tdata,   // level, col, row, r, g, b, 0
  output logic                                 m_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [mbfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbfp_pkg::DIM_W-1:0]      cfg_data
);

  localparam int NL = mbfp_pkg::MAX_LEVELS;
  localparam int LW = $clog2(NL);

  // Registers
  logic [mbfp_pkg::DIM_W-1:0] image_width, image_height;
  logic [mbfp_pkg::CNT_W-1:0] col [NL];
  logic [mbfp_pkg::CNT_W-1:0] row [NL];
  logic [mbfp_pkg::PIX_W-1:0] held [NL];
  logic                       active;
  logic [LW-1:0]              cur_lvl;
  logic [mbfp_pkg::PIX_W-1:0] cur_pix;   // {red, green, blue}

  // Per-level combinational values
  logic [mbfp_pkg::DIM_W-1:0] wc, hc;
  logic [NL-1:0]              inrange, prod, cont, more, sel, ram_we, ram_re;
  logic [mbfp_pkg::SUM_W-1:0] pair [NL];
  logic [mbfp_pkg::SUM_W-1:0] rd   [NL];
  logic [mbfp_pkg::PIX_W-1:0] avg  [NL];
  logic [mbfp_pkg::CNT_W-1:0] col_next [NL];
  logic [mbfp_pkg::CNT_W-1:0] row_next [NL];

  logic                       out_free, step, prod_sel, cont_sel, more_sel, s_acc;
  logic [mbfp_pkg::PIX_W-1:0] avg_sel;
  logic [mbfp_pkg::CNT_W-1:0] col_sel, row_sel;

  assign wc = mbfp_pkg::clamp_dim(image_width,  mbfp_pkg::DIM_W'(mbfp_pkg::MAX_WIDTH));
  assign hc = mbfp_pkg::clamp_dim(image_height, mbfp_pkg::DIM_W'(mbfp_pkg::MAX_HEIGHT));

  // Level decode: range, pair and box sums, counter advance
  always_comb begin
    logic [mbfp_pkg::DIM_W-1:0]  nw, nh, lw, lh, c1, r1;
    logic [mbfp_pkg::PSUM_W:0]   t;
    for (int l = 0; l < NL; l++) begin
      nw = wc >> (l + 1);
      nh = hc >> (l + 1);
      lw = wc >> l;
      lh = hc >> l;
      inrange[l] = (nw != '0) && (nh != '0) &&
                   ({1'b0, col[l]} < (nw << 1)) && ({1'b0, row[l]} < (nh << 1));
      prod[l]    = inrange[l] && col[l][0] && row[l][0];
      sel[l]     = step && (cur_lvl == LW'(l));
      ram_we[l]  = sel[l] && inrange[l] && col[l][0] && !row[l][0];
      ram_re[l]  = sel[l] && inrange[l] && !col[l][0] && row[l][0];
      for (int k = 0; k < 3; k++) begin
        pair[l][k*mbfp_pkg::PSUM_W +: mbfp_pkg::PSUM_W] =
          {1'b0, held[l][k*mbfp_pkg::CH_W +: mbfp_pkg::CH_W]} +
          {1'b0, cur_pix[k*mbfp_pkg::CH_W +: mbfp_pkg::CH_W]};
        t = {1'b0, rd[l][k*mbfp_pkg::PSUM_W +: mbfp_pkg::PSUM_W]} +
            {1'b0, pair[l][k*mbfp_pkg::PSUM_W +: mbfp_pkg::PSUM_W]};
        avg[l][k*mbfp_pkg::CH_W +: mbfp_pkg::CH_W] = t[mbfp_pkg::PSUM_W:2];
      end
      c1 = {1'b0, col[l]} + mbfp_pkg::DIM_W'(1);
      r1 = {1'b0, row[l]} + mbfp_pkg::DIM_W'(1);
      if (c1 >= lw) begin
        col_next[l] = '0;
        row_next[l] = (r1 >= lh) ? '0 : r1[mbfp_pkg::CNT_W-1:0];
      end else begin
        col_next[l] = c1[mbfp_pkg::CNT_W-1:0];
        row_next[l] = row[l];
      end
    end
    // a finished pixel is fed to the next level, except at the deepest level; more
    // results follow only when that level finishes one too
    for (int l = 0; l < NL - 1; l++) begin
      cont[l] = prod[l];
      more[l] = prod[l] && prod[l + 1];
    end
    cont[NL-1] = 1'b0;
    more[NL-1] = 1'b0;
  end

  // Select the level being stepped
  always_comb begin
    prod_sel = 1'b0;
    cont_sel = 1'b0;
    more_sel = 1'b0;
    avg_sel  = '0;
    col_sel  = '0;
    row_sel  = '0;
    for (int l = 0; l < NL; l++) begin
      if (cur_lvl == LW'(l)) begin
        prod_sel = prod[l];
        cont_sel = cont[l];
        more_sel = more[l];
        avg_sel  = avg[l];
        col_sel  = col[l];
        row_sel  = row[l];
      end
    end
  end

  // Handshake
  assign out_free = !m_tvalid || m_tready;
  assign step     = active && out_free;
  assign s_tready = !active || (out_free && !cont_sel);
  assign s_acc    = s_tvalid && s_tready;

  // Line stores, one per level
  for (genvar g = 0; g < NL; g++) begin : g_lvl
    localparam int D  = ((mbfp_pkg::MAX_WIDTH >> (g + 1)) < 2) ? 2
                        : (mbfp_pkg::MAX_WIDTH >> (g + 1));
    localparam int AW = $clog2(D);
    logic [mbfp_pkg::CNT_W-1:0] half;
    assign half = col[g] >> 1;
    mbfp_ram #(.WIDTH(mbfp_pkg::SUM_W), .DEPTH(D)) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (half[AW-1:0]),
      .wdata (pair[g]),
      .re    (ram_re[g]),
      .raddr (half[AW-1:0]),
      .rdata (rd[g])
    );
  end

  // Configuration and level state
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mbfp_pkg::DIM_W'(mbfp_pkg::MAX_WIDTH);
      image_height <= mbfp_pkg::DIM_W'(mbfp_pkg::MAX_HEIGHT);
      for (int l = 0; l < NL; l++) begin
        col[l]  <= '0;
        row[l]  <= '0;
        held[l] <= '0;
      end
    end else if (cfg_we && (cfg_index == mbfp_pkg::REG_WIDTH ||
                            cfg_index == mbfp_pkg::REG_HEIGHT)) begin
      if (cfg_index == mbfp_pkg::REG_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
      // a width or height write restarts the frame
      for (int l = 0; l < NL; l++) begin
        col[l]  <= '0;
        row[l]  <= '0;
        held[l] <= '0;
      end
    end else begin
      for (int l = 0; l < NL; l++) begin
        if (sel[l]) begin
          col[l] <= col_next[l];
          row[l] <= row_next[l];
          if (inrange[l] && !col[l][0]) begin
            held[l] <= cur_pix;
          end
        end
      end
    end
  end

  // Cascade control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      cur_lvl  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (step && prod_sel) begin
        m_tvalid <= 1'b1;
      end
      if (step) begin
        if (cont_sel) begin
          cur_lvl <= cur_lvl + LW'(1);
        end else begin
          active <= 1'b0;
        end
      end
      if (s_acc) begin
        active  <= 1'b1;
        cur_lvl <= '0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (step && cont_sel) begin
      cur_pix <= avg_sel;
    end
    if (s_acc) begin
      cur_pix <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    end
    if (step && prod_sel) begin
      m_tdata <= {2'b00,
                  avg_sel[7:0], avg_sel[15:8], avg_sel[23:16],
                  row_sel[mbfp_pkg::CNT_W-1:1], col_sel[mbfp_pkg::CNT_W-1:1],
                  mbfp_pkg::LVL_W'(cur_lvl) + mbfp_pkg::LVL_W'(1)};
      m_tlast <= !more_sel;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mbfp_checker.sv =====
`default_nettype none
module mbfp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tlast
);

  // A stalled result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed under stall");

  // Levels run 1..10
  a_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] != 4'd0 && m_tdata[3:0] <= 4'd10)
    else $error("mip level out of range");

  // A run continues at once with the next level
  a_cascade: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1)
    else $error("cascade broke off");

  // Nothing offered straight after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind mipmap_box_filter_pyramid_core mbfp_checker u_mbfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/mipmap_box_filter_pyramid_core_tb.sv =====
`default_nettype none
module mipmap_box_filter_pyramid_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [mbfp_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, ignored

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [mbfp_pkg::IN_W-1:0]      s_tdata = '0;   // red, green, blue
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [mbfp_pkg::OUT_W-1:0]     m_tdata;        // level, col, row, red, green, blue
  logic                           m_tlast;
  logic                           cfg_we = 1'b0;
  logic [mbfp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mbfp_pkg::DIM_W-1:0]     cfg_data = '0;

  mipmap_box_filter_pyramid_core DUT (.*);

  always #1 clk = ~clk;

  typedef struct packed {
    logic [mbfp_pkg::LVL_W-1:0] lvl;
    logic [mbfp_pkg::CRD_W-1:0] col;
    logic [mbfp_pkg::CRD_W-1:0] row;
    logic [mbfp_pkg::CH_W-1:0]  red;
    logic [mbfp_pkg::CH_W-1:0]  grn;
    logic [mbfp_pkg::CH_W-1:0]  blu;
    logic                       last;
  } mip_px_t;

  mip_px_t mip_expected[$];
  int      fail_count = 0;

  // Shadow of the pyramid state
  logic [mbfp_pkg::DIM_W-1:0]  width_reg, height_reg;
  logic [mbfp_pkg::CNT_W-1:0]  col_at [0:mbfp_pkg::MAX_LEVELS];
  logic [mbfp_pkg::CNT_W-1:0]  row_at [0:mbfp_pkg::MAX_LEVELS];
  logic [mbfp_pkg::PIX_W-1:0]  held_at [0:mbfp_pkg::MAX_LEVELS-1];
  logic [mbfp_pkg::SUM_W-1:0]  pair_store [0:mbfp_pkg::MAX_WIDTH-1];

  function automatic int unsigned dim_limit(logic [mbfp_pkg::DIM_W-1:0] v,
                                            int unsigned hi);
    if (v == '0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void restart_pyramid();
    for (int i = 0; i <= mbfp_pkg::MAX_LEVELS; i++) begin
      col_at[i] = '0;
      row_at[i] = '0;
      if (i < mbfp_pkg::MAX_LEVELS) held_at[i] = '0;
    end
  endfunction

  function automatic void write_dim(logic [mbfp_pkg::CFG_IDX_W-1:0] idx,
                                    logic [mbfp_pkg::DIM_W-1:0] val);
    if (idx == mbfp_pkg::REG_WIDTH) begin
      width_reg = val;
      restart_pyramid();
    end else if (idx == mbfp_pkg::REG_HEIGHT) begin
      height_reg = val;
      restart_pyramid();
    end
  endfunction

  // Push every pixel that this base pixel finishes, shallowest level first.
  // Internal pixel order: blue in the low byte.
  function automatic void predict_cascade(logic [mbfp_pkg::CH_W-1:0] r_in, g_in, b_in);
    int unsigned w, h, nw, nh, base, c, r, lvl, idx, first;
    logic [mbfp_pkg::PIX_W-1:0] pix, nxt;
    logic [mbfp_pkg::SUM_W-1:0] pair, top;
    logic [9:0] quad;
    bit produced;
    mip_px_t e;
    pix = {r_in, g_in, b_in};
    w = dim_limit(width_reg, mbfp_pkg::MAX_WIDTH);
    h = dim_limit(height_reg, mbfp_pkg::MAX_HEIGHT);
    base = 0;
    lvl = 0;
    first = mip_expected.size();
    while (1'b1) begin
      c = col_at[lvl];
      r = row_at[lvl];
      nw = w >> 1;
      nh = h >> 1;
      produced = 1'b0;
      nxt = '0;
      if (lvl < mbfp_pkg::MAX_LEVELS && nw != 0 && nh != 0 && c < 2 * nw && r < 2 * nh) begin
        if (c % 2 == 0) begin
          held_at[lvl] = pix;
        end else begin
          for (int k = 0; k < 3; k++)
            pair[9*k +: 9] = {1'b0, held_at[lvl][8*k +: 8]} + {1'b0, pix[8*k +: 8]};
          idx = base + c / 2;
          if (idx < mbfp_pkg::MAX_WIDTH) begin
            if (r % 2 == 0) begin
              pair_store[idx] = pair;
            end else begin
              top = pair_store[idx];
              for (int k = 0; k < 3; k++) begin
                quad = {1'b0, top[9*k +: 9]} + {1'b0, pair[9*k +: 9]};
                nxt[8*k +: 8] = quad[9:2];
              end
              e.lvl  = mbfp_pkg::LVL_W'(lvl + 1);
              e.col  = mbfp_pkg::CRD_W'(c / 2);
              e.row  = mbfp_pkg::CRD_W'(r / 2);
              e.red  = nxt[23:16];
              e.grn  = nxt[15:8];
              e.blu  = nxt[7:0];
              e.last = 1'b0;
              mip_expected.push_back(e);
              produced = 1'b1;
            end
          end
        end
      end
      // advance this level's raster position, wrapping at frame end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_at[lvl] = mbfp_pkg::CNT_W'(c);
      row_at[lvl] = mbfp_pkg::CNT_W'(r);
      if (!produced) break;
      pix = nxt;
      base += nw;
      w = nw;
      h = nh;
      lvl++;
    end
    if (mip_expected.size() > first) mip_expected[mip_expected.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    mip_px_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[3:0], m_tdata[12:4], m_tdata[21:13], m_tdata[29:22],
             m_tdata[37:30], m_tdata[45:38], m_tlast};
      if (mip_expected.size() == 0) begin
        report_mismatch("unexpected beat, level", got.lvl, 0);
      end else begin
        want = mip_expected.pop_front();
        if (got.lvl  != want.lvl)  report_mismatch("mip_level", got.lvl, want.lvl);
        if (got.col  != want.col)  report_mismatch("column", got.col, want.col);
        if (got.row  != want.row)  report_mismatch("row", got.row, want.row);
        if (got.red  != want.red)  report_mismatch("red_out", got.red, want.red);
        if (got.grn  != want.grn)  report_mismatch("green_out", got.grn, want.grn);
        if (got.blu  != want.blu)  report_mismatch("blue_out", got.blu, want.blu);
        if (got.last != want.last) report_mismatch("last_of_run", got.last, want.last);
        if (m_tdata[47:46] != 2'b00) report_mismatch("tdata pad", m_tdata[47:46], 0);
      end
    end
  end

  // Result-side stalls
  initial begin
    int stall_left, pick;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        pick = $urandom_range(0, 19);
        if (pick < 3) stall_left = $urandom_range(1, 3);
        else if (pick == 3) stall_left = $urandom_range(15, 40);
      end
    end
  end

  // Send one pixel beat; called at a falling edge, returns at a falling edge
  task automatic send_pixel(logic [mbfp_pkg::CH_W-1:0] r, g, b, bit busy);
    int pick, gap;
    gap = 0;
    if (!busy) begin
      pick = $urandom_range(0, 9);
      if (pick >= 5 && pick < 9) gap = $urandom_range(1, 3);
      else if (pick == 9) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {b, g, r};
    do @(posedge clk); while (!s_tready);
    predict_cascade(r, g, b);
    @(negedge clk);
  endtask

  // Drain, let a possibly resultless pixel finish, then write a register
  task automatic write_reg(logic [mbfp_pkg::CFG_IDX_W-1:0] idx,
                           logic [mbfp_pkg::DIM_W-1:0] val);
    s_tvalid = 1'b0;
    while (mip_expected.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    write_dim(idx, val);
  endtask

  // Directed stimulus table
  typedef struct {
    bit                             is_cfg;
    logic [mbfp_pkg::CFG_IDX_W-1:0] idx;
    logic [mbfp_pkg::DIM_W-1:0]     val;
    logic [mbfp_pkg::CH_W-1:0]      r, g, b;
    bit                             typed;
    mip_px_t                        want;
  } stim_row_t;

  stim_row_t stim_rows[$];

  task automatic add_cfg(logic [mbfp_pkg::CFG_IDX_W-1:0] idx,
                         logic [mbfp_pkg::DIM_W-1:0] val);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    stim_rows.push_back(s);
  endtask

  task automatic add_px(logic [mbfp_pkg::CH_W-1:0] r, g, b, bit typed = 0,
                        mip_px_t want = '0);
    stim_row_t s;
    s = '{default: '0};
    s.r = r;
    s.g = g;
    s.b = b;
    s.typed = typed;
    s.want = want;
    stim_rows.push_back(s);
  endtask

  initial begin
    int total, pick, w, h, n;
    bit busy;
    width_reg  = mbfp_pkg::DIM_W'(1024);
    height_reg = mbfp_pkg::DIM_W'(1024);
    restart_pyramid();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset dimensions: nothing completes yet
    add_px(8'h12, 8'h34, 8'h56);
    add_px(8'hff, 8'h00, 8'hff);
    // 2x2 frames: extremes average to themselves
    add_cfg(mbfp_pkg::REG_WIDTH, 11'd2);
    add_cfg(mbfp_pkg::REG_HEIGHT, 11'd2);
    repeat (3) add_px(8'hff, 8'hff, 8'hff);
    add_px(8'hff, 8'hff, 8'hff, 1, '{4'd1, 9'd0, 9'd0, 8'hff, 8'hff, 8'hff, 1'b1});
    repeat (3) add_px(8'h00, 8'h00, 8'h00);
    add_px(8'h00, 8'h00, 8'h00, 1, '{4'd1, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00, 1'b1});
    add_px(8'hff, 8'h00, 8'h80);
    add_px(8'h01, 8'hff, 8'h7f);
    add_px(8'h00, 8'h01, 8'hff);
    add_px(8'hfe, 8'h80, 8'h00);
    // unmapped index is ignored and keeps the frame position
    add_cfg(REG_SPARE, 11'd5);
    // zero dimensions count as one: no level exists
    add_cfg(mbfp_pkg::REG_WIDTH, 11'd0);
    add_cfg(mbfp_pkg::REG_HEIGHT, 11'd0);
    add_px(8'haa, 8'h55, 8'hff);
    add_px(8'h55, 8'haa, 8'h00);
    // oversize saturates to the maximum
    add_cfg(mbfp_pkg::REG_WIDTH, 11'h7ff);
    add_cfg(mbfp_pkg::REG_HEIGHT, 11'h7ff);
    add_px(8'h80, 8'h80, 8'h80);
    add_px(8'h7f, 8'h7f, 8'h7f);
    // 3x3: odd last column and row dropped
    add_cfg(mbfp_pkg::REG_WIDTH, 11'd3);
    add_cfg(mbfp_pkg::REG_HEIGHT, 11'd3);
    for (int i = 0; i < 9; i++) add_px(8'(i * 29), 8'(255 - i * 17), 8'(i * 97));

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        write_reg(stim_rows[i].idx, stim_rows[i].val);
      end else begin
        send_pixel(stim_rows[i].r, stim_rows[i].g, stim_rows[i].b, 1'b0);
        if (stim_rows[i].typed && mip_expected.size() != 0)
          mip_expected[mip_expected.size()-1] = stim_rows[i].want;
      end
    end

    // Random phases: mostly small frames, a few odd or huge settings
    total = 0;
    while (total < 370) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        w = $urandom_range(0, 2047);
        h = $urandom_range(0, 2047);
        n = 30;
      end else begin
        w = (pick == 1) ? $urandom_range(13, 20) : $urandom_range(1, 12);
        h = $urandom_range(1, 12);
        n = (w * h * 2 > 70) ? 70 : w * h * 2;
        if (n < 6) n = 6;
      end
      write_reg(mbfp_pkg::REG_WIDTH, mbfp_pkg::DIM_W'(w));
      write_reg(mbfp_pkg::REG_HEIGHT, mbfp_pkg::DIM_W'(h));
      busy = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++)
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), busy);
      total += n;
    end

    s_tvalid = 1'b0;
    while (mip_expected.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && mip_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
